FILE: rtl/palh_pkg.sv
// ----------------------------------------------------------------------------
// palh_pkg
// Shared types, constants and the arctangent table for the path arc length
// and heading block.
// ----------------------------------------------------------------------------
package palh_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COORD_BITS_DEF   = 24;

	localparam int OUT_W      = 24;
	localparam int ARC_W      = 32;
	localparam int HD_W       = 16;
	localparam int ANG_W      = 32;
	localparam int GUARD_BITS = 8;
	localparam int GAIN_BITS  = 20;
	localparam int MUL_SPLIT  = 21;
	localparam int ATAN_IW    = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [GAIN_BITS-1:0] INV_GAIN  = 20'd636751;
	localparam logic [ANG_W-1:0]     HALF_TURN = 32'h8000_0000;
	localparam logic [ANG_W-1:0]     HD_ROUND  = 32'h0000_8000;

	typedef enum logic {
		OP_SINGLE,
		OP_SEGMENT
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic                    first;
		logic                    last;
		logic signed [OUT_W-1:0] prev_x;
		logic signed [OUT_W-1:0] prev_y;
		logic signed [OUT_W-1:0] cur_x;
		logic signed [OUT_W-1:0] cur_y;
	} entry_t;

	function automatic logic [ANG_W-1:0] atan_bam(input logic [ATAN_IW-1:0] idx);
		logic [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/palh_front.sv
// ----------------------------------------------------------------------------
// palh_front
// Accepts path points, holds the previous point and classifies each point
// into a one-point path or a segment for the back end.
// ----------------------------------------------------------------------------
module palh_front #(
	parameter int COORD_BITS = palh_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         end_of_path,
	output logic                         push,
	input  logic                         full,
	output palh_pkg::entry_t             entry,
	output logic signed [COORD_BITS:0]   dx,
	output logic signed [COORD_BITS:0]   dy
);
	import palh_pkg::*;

	localparam int DW = COORD_BITS + 1;

	logic signed [COORD_BITS-1:0] held_x_q;
	logic signed [COORD_BITS-1:0] held_y_q;
	logic                         have_held_q;
	logic                         first_q;
	logic                         accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept && (have_held_q || end_of_path);

	assign dx = DW'(point_x) - DW'(held_x_q);
	assign dy = DW'(point_y) - DW'(held_y_q);

	always_comb begin
		entry.op     = have_held_q ? OP_SEGMENT : OP_SINGLE;
		entry.first  = first_q;
		entry.last   = end_of_path;
		entry.prev_x = OUT_W'(held_x_q);
		entry.prev_y = OUT_W'(held_y_q);
		entry.cur_x  = OUT_W'(point_x);
		entry.cur_y  = OUT_W'(point_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			have_held_q <= 1'b0;
			first_q     <= 1'b0;
		end else if (accept) begin
			held_x_q    <= point_x;
			held_y_q    <= point_y;
			have_held_q <= !end_of_path;
			first_q     <= !have_held_q;
		end
	end

endmodule

FILE: rtl/palh_queue.sv
// ----------------------------------------------------------------------------
// palh_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module palh_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = palh_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import palh_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/palh_back.sv
// ----------------------------------------------------------------------------
// palh_back
// Iterative vectoring unit for segment length and heading, gain scaling,
// saturating arc accumulation and result emission.
// ----------------------------------------------------------------------------
module palh_back #(
	parameter int CORDIC_STEPS = palh_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_BITS   = palh_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  palh_pkg::entry_t                  q_entry,
	input  logic signed [COORD_BITS:0]        q_dx,
	input  logic signed [COORD_BITS:0]        q_dy,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [palh_pkg::OUT_W-1:0] out_x,
	output logic signed [palh_pkg::OUT_W-1:0] out_y,
	output logic [palh_pkg::ARC_W-1:0]        arc_length,
	output logic signed [palh_pkg::HD_W-1:0]  heading,
	output logic                              last_of_path
);
	import palh_pkg::*;

	localparam int DW        = COORD_BITS + 1;
	localparam int CW        = DW + GUARD_BITS + 2;
	localparam int IW        = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int HW        = CW - MUL_SPLIT;
	localparam int LPW       = MUL_SPLIT + GAIN_BITS;
	localparam int HPW       = HW + GAIN_BITS;
	localparam int FW        = CW + GAIN_BITS + 1;
	localparam int ROUND_POS = GAIN_BITS + GUARD_BITS;
	localparam int LW        = FW - ROUND_POS;
	localparam int SW        = ((LW > ARC_W) ? LW : ARC_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROT,
		S_MUL_LO,
		S_MUL_HI,
		S_LEN,
		S_SUM,
		S_EMIT_SEG,
		S_EMIT_END
	} state_t;

	state_t                  state_q;
	logic [IW-1:0]           cnt_q;
	logic [ARC_W-1:0]        arc_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_x_q;
	logic signed [OUT_W-1:0] out_y_q;
	logic [ARC_W-1:0]        out_arc_q;
	logic signed [HD_W-1:0]  out_hd_q;
	logic                    out_last_q;

	logic signed [CW-1:0]    x_q;
	logic signed [CW-1:0]    y_q;
	logic [ANG_W-1:0]        z_q;
	logic                    zero_q;
	logic                    first_q;
	logic                    last_q;
	logic signed [OUT_W-1:0] prev_x_q;
	logic signed [OUT_W-1:0] prev_y_q;
	logic signed [OUT_W-1:0] cur_x_q;
	logic signed [OUT_W-1:0] cur_y_q;
	logic [LPW-1:0]          p_lo_q;
	logic [HPW-1:0]          p_hi_q;
	logic [LW-1:0]           len_q;
	logic [ARC_W-1:0]        base_q;
	logic signed [HD_W-1:0]  hd_q;

	logic                    out_free;
	logic                    emit_go;
	logic signed [CW-1:0]    xi;
	logic signed [CW-1:0]    yi;
	logic signed [CW-1:0]    sx;
	logic signed [CW-1:0]    sy;
	logic [ANG_W-1:0]        atan_v;
	logic [ANG_W-1:0]        z_rnd;
	logic [CW-1:0]           mag;
	logic [LPW-1:0]          prod_lo;
	logic [HPW-1:0]          prod_hi;
	logic [FW-1:0]           full_sum;
	logic [ARC_W-1:0]        base_v;
	logic [SW-1:0]           arc_sum;
	logic [ARC_W-1:0]        arc_sat;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_go  = out_free && ((state_q == S_EMIT_SEG) || (state_q == S_EMIT_END));

	assign xi     = CW'(q_dx) <<< GUARD_BITS;
	assign yi     = CW'(q_dy) <<< GUARD_BITS;
	assign sx     = x_q >>> cnt_q;
	assign sy     = y_q >>> cnt_q;
	assign atan_v = atan_bam(ATAN_IW'(cnt_q));
	assign z_rnd  = z_q + HD_ROUND;

	assign mag      = (!x_q[CW-1] && (x_q != '0)) ? x_q : '0;
	assign prod_lo  = LPW'(mag[MUL_SPLIT-1:0]) * LPW'(INV_GAIN);
	assign prod_hi  = HPW'(mag[CW-1:MUL_SPLIT]) * HPW'(INV_GAIN);
	assign full_sum = (FW'(p_hi_q) << MUL_SPLIT) + FW'(p_lo_q) + (FW'(1) << (ROUND_POS - 1));

	assign base_v  = first_q ? '0 : arc_q;
	assign arc_sum = SW'(base_v) + SW'(len_q);
	assign arc_sat = (|arc_sum[SW-1:ARC_W]) ? '1 : arc_sum[ARC_W-1:0];

	// sequencer, arc state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			arc_q       <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_arc_q   <= '0;
			out_hd_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						if (q_entry.op == OP_SINGLE) begin
							arc_q   <= '0;
							state_q <= S_EMIT_END;
						end else begin
							state_q <= S_ROT;
						end
					end
				end
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_LEN;
				S_LEN:    state_q <= S_SUM;
				S_SUM: begin
					arc_q   <= arc_sat;
					state_q <= S_EMIT_SEG;
				end
				S_EMIT_SEG: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_x_q     <= prev_x_q;
						out_y_q     <= prev_y_q;
						out_arc_q   <= base_q;
						out_hd_q    <= hd_q;
						out_last_q  <= 1'b0;
						state_q     <= last_q ? S_EMIT_END : S_IDLE;
					end
				end
				S_EMIT_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_x_q     <= cur_x_q;
						out_y_q     <= cur_y_q;
						out_arc_q   <= arc_q;
						out_hd_q    <= hd_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					first_q  <= q_entry.first;
					last_q   <= q_entry.last;
					prev_x_q <= q_entry.prev_x;
					prev_y_q <= q_entry.prev_y;
					cur_x_q  <= q_entry.cur_x;
					cur_y_q  <= q_entry.cur_y;
					zero_q   <= (q_dx == '0) && (q_dy == '0);
					hd_q     <= '0;
					if (q_dx < 0) begin
						x_q <= -xi;
						y_q <= -yi;
						z_q <= HALF_TURN;
					end else begin
						x_q <= xi;
						y_q <= yi;
						z_q <= '0;
					end
				end
			end
			S_ROT: begin
				if (y_q[CW-1]) begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					z_q <= z_q + atan_v;
				end
			end
			S_MUL_LO: begin
				p_lo_q <= prod_lo;
				hd_q   <= zero_q ? '0 : z_rnd[ANG_W-1:ANG_W-HD_W];
			end
			S_MUL_HI: p_hi_q <= prod_hi;
			S_LEN:    len_q  <= zero_q ? '0 : full_sum[FW-1:ROUND_POS];
			S_SUM:    base_q <= base_v;
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign arc_length   = out_arc_q;
	assign heading      = out_hd_q;
	assign last_of_path = out_last_q;

endmodule

FILE: rtl/path_arc_length_heading.sv
// ----------------------------------------------------------------------------
// path_arc_length_heading
// Cumulative arc length and heading of a stream of path points.
// ----------------------------------------------------------------------------
// Input transactions carry one path point each, with end_of_path on the
// final point. Every point after the first of a path gives one result: the
// previous point with its arc length and the heading toward the new point.
// The final point gives a second result with last_of_path set, carrying the
// heading of the segment before it. A path of one point gives one result
// with arc length and heading zero.
// Both channels use valid and stall; a transaction completes when valid is
// high and stall is low.
// A segment passes through the back end in order: a load step, one vectoring
// iteration per CORDIC step, a low and a high half of the split gain
// multiply, rounding, accumulation and emission; the final point adds a
// second emit step for its second result. A one-point path is loaded and
// emitted directly. The iterative vectoring unit sets the rate.
// A two-entry queue lets the front accept points while the back end works;
// in_stall rises only when that queue is full. A stalled receiver holds the
// output register and the back end waits in its emit step.
// Reset clears the held point, the arc and all pending transactions.
// ----------------------------------------------------------------------------
module path_arc_length_heading #(
	parameter int CORDIC_STEPS = palh_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_BITS   = palh_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COORD_BITS-1:0]      point_x,
	input  logic signed [COORD_BITS-1:0]      point_y,
	input  logic                              end_of_path,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [palh_pkg::OUT_W-1:0] out_x,
	output logic signed [palh_pkg::OUT_W-1:0] out_y,
	output logic [palh_pkg::ARC_W-1:0]        arc_length,
	output logic signed [palh_pkg::HD_W-1:0]  heading,
	output logic                              last_of_path
);
	import palh_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int EW = $bits(entry_t);
	localparam int QW = EW + 2 * DW;

	logic                 f_push;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	entry_t               f_entry;
	entry_t               q_entry;
	logic signed [DW-1:0] f_dx;
	logic signed [DW-1:0] f_dy;
	logic signed [DW-1:0] q_dx;
	logic signed [DW-1:0] q_dy;
	logic [QW-1:0]        q_wdata;
	logic [QW-1:0]        q_rdata;

	palh_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.end_of_path(end_of_path),
		.push       (f_push),
		.full       (q_full),
		.entry      (f_entry),
		.dx         (f_dx),
		.dy         (f_dy)
	);

	assign q_wdata = {f_dx, f_dy, f_entry};

	palh_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign q_entry = q_rdata[EW-1:0];
	assign q_dy    = q_rdata[EW+DW-1:EW];
	assign q_dx    = q_rdata[EW+2*DW-1:EW+DW];

	palh_back #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_entry     (q_entry),
		.q_dx        (q_dx),
		.q_dy        (q_dy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.arc_length  (arc_length),
		.heading     (heading),
		.last_of_path(last_of_path)
	);

endmodule

FILE: rtl/palh_checker.sv
// ----------------------------------------------------------------------------
// palh_checker
// Port-level checks on the result channel of path_arc_length_heading.
// ----------------------------------------------------------------------------
module palh_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [palh_pkg::OUT_W-1:0] out_x,
	input  logic signed [palh_pkg::OUT_W-1:0] out_y,
	input  logic [palh_pkg::ARC_W-1:0]        arc_length,
	input  logic signed [palh_pkg::HD_W-1:0]  heading,
	input  logic                              last_of_path
);
	import palh_pkg::*;

	logic             out_take;
	logic             seen_q;
	logic             prev_last_q;
	logic [ARC_W-1:0] prev_arc_q;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			prev_last_q <= 1'b0;
			prev_arc_q  <= '0;
		end else if (out_take) begin
			seen_q      <= 1'b1;
			prev_last_q <= last_of_path;
			prev_arc_q  <= arc_length;
		end
	end

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_x) && $stable(out_y) &&
			$stable(arc_length) && $stable(heading) && $stable(last_of_path))
		else $error("stalled result changed");

	// within a path the arc never goes back
	a_arc_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && seen_q && !prev_last_q |-> arc_length >= prev_arc_q)
		else $error("arc length decreased within a path");

	// a final point at zero distance has no heading to carry
	a_zero_path_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_path && (arc_length == '0) |-> heading == '0)
		else $error("zero-length path with non-zero heading");

endmodule

bind path_arc_length_heading palh_checker u_palh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_x       (out_x),
	.out_y       (out_y),
	.arc_length  (arc_length),
	.heading     (heading),
	.last_of_path(last_of_path)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the path arc length and heading block against a predictor.
// ----------------------------------------------------------------------------
// A short table of paths covers one-point paths, repeated points, the
// coordinate extremes and the four axis directions. Random paths follow:
// random walks with mixed step sizes, and one long zigzag between opposite
// corners that drives the arc length into saturation. Every result is
// compared field by field with the predicted one. Both sides idle in random
// bursts. The receiver holds off once for a long stretch so that the block
// fills, and the sender waits once for the block to drain.
// ----------------------------------------------------------------------------
module testbench;
	import palh_pkg::*;

	localparam int CW          = COORD_BITS_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_FROM    = 850;
	localparam int ZIGZAG_LEN   = 200;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 40;
	localparam int STUCK_LIMIT  = 3000;

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic [0:31][ANG_W-1:0] ATAN_STEP = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [ARC_W-1:0]        arc;
		logic signed [HD_W-1:0]  hd;
		logic                    last;
	} report_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 eop;
		logic                 typed;
		logic [1:0]           n;
		report_t              r0;
		report_t              r1;
	} stim_row_t;

	localparam report_t NO_REPORT = '0;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [CW-1:0]        point_x = '0;
	logic signed [CW-1:0]        point_y = '0;
	logic                        end_of_path = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [OUT_W-1:0]     out_x;
	logic signed [OUT_W-1:0]     out_y;
	logic [ARC_W-1:0]            arc_length;
	logic signed [HD_W-1:0]      heading;
	logic                        last_of_path;

	// predictor state
	logic signed [CW-1:0] path_x;
	logic signed [CW-1:0] path_y;
	logic [ARC_W-1:0]     path_arc;
	logic [HD_W-1:0]      path_hd;
	bit                   path_open;

	report_t owed_reports[$];
	int      fails = 0;
	int      reports_seen = 0;
	int      stuck_cycles = 0;
	bit      calm = 1'b0;
	bit      gappy = 1'b0;

	path_arc_length_heading u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.end_of_path  (end_of_path),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.arc_length   (arc_length),
		.heading      (heading),
		.last_of_path (last_of_path)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic report_t report_of(input logic signed [OUT_W-1:0] x, y,
			input logic [ARC_W-1:0] arc, input logic signed [HD_W-1:0] hd, input logic last);
		return '{x, y, arc, hd, last};
	endfunction

	function automatic stim_row_t free_row(input logic signed [CW-1:0] x, y, input logic eop);
		return '{x, y, eop, 1'b0, 2'd0, NO_REPORT, NO_REPORT};
	endfunction

	// segment length in 1/1024 m and heading, by cordic vectoring
	function automatic void segment_polar(input longint dx, dy,
			output longint unsigned len, output logic [HD_W-1:0] hd);
		longint           cx;
		longint           cy;
		longint           nx;
		logic [ANG_W-1:0] ang;
		logic [ANG_W-1:0] rounded;
		longint unsigned  mag;
		len = 0;
		hd = '0;
		if (dx == 0 && dy == 0)
			return;
		cx = dx <<< GUARD_BITS;
		cy = dy <<< GUARD_BITS;
		ang = '0;
		if (cx < 0) begin
			cx = -cx;
			cy = -cy;
			ang = HALF_TURN;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
			if (cy < 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				ang = ang - ATAN_STEP[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				ang = ang + ATAN_STEP[i];
			end
			cx = nx;
		end
		mag = (cx > 0) ? cx : 0;
		len = (mag * INV_GAIN + (64'd1 << (GAIN_BITS + GUARD_BITS - 1)))
			>> (GAIN_BITS + GUARD_BITS);
		rounded = ang + HD_ROUND;
		hd = rounded[ANG_W-1 -: HD_W];
	endfunction

	// takes one point, returns the number of reports it produces
	function automatic int advance_path(input logic signed [CW-1:0] px, py, input logic eop,
			output report_t r0, output report_t r1);
		longint unsigned seg_len;
		longint unsigned total;
		logic [HD_W-1:0] seg_hd;
		r0 = NO_REPORT;
		r1 = NO_REPORT;
		if (!path_open) begin
			path_x = px;
			path_y = py;
			path_arc = '0;
			path_hd = '0;
			path_open = 1'b1;
			if (eop) begin
				r0 = report_of(px, py, '0, '0, 1'b1);
				path_open = 1'b0;
				return 1;
			end
			return 0;
		end
		segment_polar(longint'(px) - longint'(path_x), longint'(py) - longint'(path_y),
			seg_len, seg_hd);
		r0 = report_of(path_x, path_y, path_arc, seg_hd, 1'b0);
		total = path_arc + seg_len;
		path_arc = (total > 64'hFFFF_FFFF) ? '1 : total[ARC_W-1:0];
		path_x = px;
		path_y = py;
		path_hd = seg_hd;
		if (eop) begin
			r1 = report_of(px, py, path_arc, path_hd, 1'b1);
			path_open = 1'b0;
			return 2;
		end
		return 1;
	endfunction

	task automatic offer(input stim_row_t row);
		report_t p0;
		report_t p1;
		int      n;
		if (!calm && gappy && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= row.x;
		point_y <= row.y;
		end_of_path <= row.eop;
		do @(posedge clk); while (in_stall !== 1'b0);
		n = advance_path(row.x, row.y, row.eop, p0, p1);
		if (row.typed) begin
			n = int'(row.n);
			p0 = row.r0;
			p1 = row.r1;
		end
		if (n > 0)
			owed_reports.insert(owed_reports.size(), p0);
		if (n > 1)
			owed_reports.insert(owed_reports.size(), p1);
	endtask

	initial begin : stimulus
		stim_row_t            directed_rows [20];
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		int                   random_sent;
		int                   len;
		int                   span;
		int                   pick;
		bit                   zigzag_done;
		bit                   paused;
		directed_rows = '{
			'{24'sd0, 24'sd0, 1'b1, 1'b1, 2'd1, report_of(0, 0, 0, 0, 1), NO_REPORT},
			'{C_MAX, C_MIN, 1'b1, 1'b1, 2'd1, report_of(C_MAX, C_MIN, 0, 0, 1), NO_REPORT},
			'{C_MIN, C_MAX, 1'b1, 1'b1, 2'd1, report_of(C_MIN, C_MAX, 0, 0, 1), NO_REPORT},
			'{24'sd5, -24'sd7, 1'b0, 1'b1, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd5, -24'sd7, 1'b1, 1'b1, 2'd2, report_of(5, -7, 0, 0, 0),
				report_of(5, -7, 0, 0, 1)},
			'{C_MIN, C_MIN, 1'b0, 1'b1, 2'd0, NO_REPORT, NO_REPORT},
			'{C_MAX, C_MAX, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{C_MIN, C_MAX, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{C_MAX, C_MIN, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{C_MAX, C_MAX, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{C_MAX, C_MAX, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd0, 24'sd0, 1'b0, 1'b1, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd100, 24'sd0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd100, 24'sd100, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd0, 24'sd100, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd0, 24'sd0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{-24'sd1, 24'sd0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{-24'sd1, -24'sd1, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{-24'sd1, 24'sd1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
			'{24'sd1, -24'sd1, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT}
		};
		path_x = '0;
		path_y = '0;
		path_arc = '0;
		path_hd = '0;
		path_open = 1'b0;
		random_sent = 0;
		zigzag_done = 1'b0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gappy = 1'b1;
		foreach (directed_rows[i])
			offer(directed_rows[i]);

		while (random_sent < RANDOM_ITEMS) begin
			calm = (random_sent >= CALM_FROM);
			gappy = ($urandom_range(0, 9) < 6);
			if (!zigzag_done && random_sent >= 300) begin
				// corner to corner, long enough for the arc length to saturate
				zigzag_done = 1'b1;
				for (int j = 0; j < ZIGZAG_LEN; j++)
					offer(free_row(j[0] ? C_MAX : C_MIN, j[0] ? C_MAX : C_MIN,
						j == ZIGZAG_LEN - 1));
				random_sent += ZIGZAG_LEN;
			end else if (!paused && random_sent >= 500) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (owed_reports.size() != 0);
			end else if ($urandom_range(0, 19) == 0) begin
				px = CW'($urandom);
				py = CW'($urandom);
				offer(free_row(px, py, 1'b1));
				random_sent++;
			end else begin
				len = $urandom_range(2, 16);
				px = CW'($urandom);
				py = CW'($urandom);
				for (int j = 0; j < len; j++) begin
					pick = $urandom_range(0, 19);
					if (j > 0 && pick == 0) begin
						// repeated point
					end else if (pick < 5) begin
						px = CW'($urandom);
						py = CW'($urandom);
					end else begin
						span = 1 << $urandom_range(0, 22);
						px = CW'(px + ($urandom_range(0, 2 * span) - span));
						py = CW'(py + ($urandom_range(0, 2 * span) - span));
					end
					offer(free_row(px, py, j == len - 1));
				end
				random_sent += len;
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (owed_reports.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : receiver
		bit long_done;
		long_done = 1'b0;
		@(posedge clk);
		forever begin
			if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!long_done && reports_seen >= 100) begin
				long_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 9) < 3) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 150 : 20))
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : report_check
		report_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			reports_seen++;
			if (owed_reports.size() == 0) begin
				fails++;
				$error("unexpected transaction: out_x %0d, out_y %0d", out_x, out_y);
			end else begin
				want = owed_reports.pop_front();
				if (out_x !== want.x) begin
					fails++;
					$error("out_x: expected %0d, got %0d", want.x, out_x);
				end
				if (out_y !== want.y) begin
					fails++;
					$error("out_y: expected %0d, got %0d", want.y, out_y);
				end
				if (arc_length !== want.arc) begin
					fails++;
					$error("arc_length: expected %0d, got %0d", want.arc, arc_length);
				end
				if (heading !== want.hd) begin
					fails++;
					$error("heading: expected %0d, got %0d", want.hd, heading);
				end
				if (last_of_path !== want.last) begin
					fails++;
					$error("last_of_path: expected %0d, got %0d", want.last, last_of_path);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

FILE: path_arc_length_heading.f
rtl/palh_pkg.sv
rtl/palh_front.sv
rtl/palh_queue.sv
rtl/palh_back.sv
rtl/path_arc_length_heading.sv
rtl/palh_checker.sv
test/testbench.sv
